// File: hdl/scbc_pkg.sv
// Shared types and constants for the second-chance block cache tag engine.
`default_nettype none

package scbc_pkg;

    localparam int unsigned FILE_BITS   = 8;
    localparam int unsigned OFFSET_BITS = 48;
    localparam int unsigned TAG_W       = FILE_BITS + OFFSET_BITS;

    localparam int unsigned ADDR_W            = 2;
    localparam logic [ADDR_W-1:0] REG_CAPACITY = 2'd0;
    localparam int unsigned CFG_CAP_BITS      = 5;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_FLUSH = 2'd2,
        KIND_CLOSE = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [FILE_BITS-1:0]   file_id;
        logic [OFFSET_BITS-1:0] block_offset;
    } in_item_t;

    typedef struct packed {
        logic                   hit;
        logic                   evicted;
        logic                   writeback;
        logic [FILE_BITS-1:0]   out_file;
        logic [OFFSET_BITS-1:0] out_offset;
        logic                   last;
    } out_item_t;

    typedef struct packed {
        logic [FILE_BITS-1:0]   tag_file;
        logic [OFFSET_BITS-1:0] tag_offset;
    } tag_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_VSCAN,
        S_PACK,
        S_APPEND,
        S_FLUSH,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: hdl/scbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module scbc_ram #(
    parameter int unsigned WIDTH = 56,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/second_chance_block_cache_tags_top.sv
// Top level: second-chance tag store, scan sequencer and APB capacity register.
// Steps: a lookup scan ends at a hit; a miss on a full store runs a second-chance
//   scan and a compaction pass that drops the victim before the append.
// Throughput: one item at a time, every scan step visits one entry per cycle
//   through the single read port of the tag RAM unless a flush waits on a stalled
//   output; the next item is taken once the final result has been loaded.
// Reset: marks and entry count cleared, capacity set to DEPTH; tag RAM not cleared.
`default_nettype none

module second_chance_block_cache_tags_top #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire scbc_pkg::in_item_t             s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output scbc_pkg::out_item_t                 m_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [scbc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);

    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CAP_W = (CNT_W > scbc_pkg::CFG_CAP_BITS) ?
                                    CNT_W : scbc_pkg::CFG_CAP_BITS;

    scbc_pkg::state_t    state_reg, state_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    wptr_reg, wptr_next;
    logic [CNT_W-1:0]    victim_reg, victim_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CAP_W-1:0]    cap_reg;
    logic [DEPTH-1:0]    ref_reg, ref_next;
    logic [DEPTH-1:0]    dirty_reg, dirty_next;
    scbc_pkg::in_item_t  req_reg, req_next;
    scbc_pkg::out_item_t res_reg, res_next;
    logic                m_valid_reg;
    scbc_pkg::out_item_t m_data_reg;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [scbc_pkg::TAG_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [scbc_pkg::TAG_W-1:0] ram_rdata;
    scbc_pkg::tag_t             tag_rd;

    logic [AW-1:0]       idx_a, wptr_a, cnt_a;
    logic                at_end, file_match, look_match, ref_cur, dirty_cur;
    logic                full, vscan_found, pack_drop, out_free, out_load;
    logic [CAP_W-1:0]    eff_cap;
    logic [CNT_W-1:0]    idx_inc;
    scbc_pkg::out_item_t out_data;
    scbc_pkg::tag_t      app_tag;

    scbc_ram #(
        .WIDTH (scbc_pkg::TAG_W),
        .DEPTH (DEPTH)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign tag_rd     = scbc_pkg::tag_t'(ram_rdata);
    assign idx_a      = idx_reg[AW-1:0];
    assign wptr_a     = wptr_reg[AW-1:0];
    assign cnt_a      = count_reg[AW-1:0];
    assign idx_inc    = idx_reg + 1'b1;
    assign at_end     = (idx_reg == count_reg);
    assign file_match = (tag_rd.tag_file == req_reg.file_id);
    assign look_match = file_match && (tag_rd.tag_offset == req_reg.block_offset);
    assign ref_cur    = ref_reg[idx_a];
    assign dirty_cur  = dirty_reg[idx_a];
    assign out_free   = !m_valid_reg || m_ready;
    assign vscan_found = at_end || !ref_cur;
    assign pack_drop  = (req_reg.kind == scbc_pkg::KIND_CLOSE) ? file_match :
                        (idx_reg == victim_reg);
    assign app_tag    = '{tag_file: req_reg.file_id, tag_offset: req_reg.block_offset};

    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CAP_W'(1);
        end else if (cap_reg > CAP_W'(DEPTH)) begin
            eff_cap = CAP_W'(DEPTH);
        end else begin
            eff_cap = cap_reg;
        end
    end

    assign full = (CAP_W'(count_reg) >= eff_cap) && (count_reg != '0);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            scbc_pkg::S_IDLE: begin
                if (s_valid) begin
                    unique case (s_data.kind) inside
                        scbc_pkg::KIND_READ, scbc_pkg::KIND_WRITE: state_next = scbc_pkg::S_LOOK;
                        scbc_pkg::KIND_FLUSH: state_next = scbc_pkg::S_FLUSH;
                        default:              state_next = scbc_pkg::S_PACK;
                    endcase
                end
            end
            scbc_pkg::S_LOOK: begin
                if (at_end) begin
                    state_next = full ? scbc_pkg::S_VSCAN : scbc_pkg::S_APPEND;
                end else if (look_match) begin
                    state_next = scbc_pkg::S_EMIT;
                end
            end
            scbc_pkg::S_VSCAN: begin
                if (vscan_found) begin
                    state_next = scbc_pkg::S_PACK;
                end
            end
            scbc_pkg::S_PACK: begin
                if (at_end) begin
                    state_next = (req_reg.kind == scbc_pkg::KIND_CLOSE) ?
                                 scbc_pkg::S_EMIT : scbc_pkg::S_APPEND;
                end
            end
            scbc_pkg::S_APPEND: state_next = scbc_pkg::S_EMIT;
            scbc_pkg::S_FLUSH: begin
                if (at_end) begin
                    state_next = scbc_pkg::S_EMIT;
                end
            end
            scbc_pkg::S_EMIT: begin
                if (out_free) begin
                    state_next = scbc_pkg::S_IDLE;
                end
            end
            default: state_next = scbc_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        idx_next    = idx_reg;
        wptr_next   = wptr_reg;
        victim_next = victim_reg;
        count_next  = count_reg;
        ref_next    = ref_reg;
        dirty_next  = dirty_reg;
        req_next    = req_reg;
        res_next    = res_reg;
        ram_we      = 1'b0;
        ram_waddr   = wptr_a;
        ram_wdata   = ram_rdata;
        ram_raddr   = idx_inc[AW-1:0];
        out_load    = 1'b0;
        out_data    = '0;
        unique case (state_reg)
            scbc_pkg::S_IDLE: begin
                ram_raddr = '0;
                if (s_valid) begin
                    req_next  = s_data;
                    idx_next  = '0;
                    wptr_next = '0;
                    res_next  = '0;
                end
            end
            scbc_pkg::S_LOOK: begin
                if (at_end) begin
                    idx_next = '0;
                end else if (look_match) begin
                    ref_next[idx_a] = 1'b1;
                    if (req_reg.kind == scbc_pkg::KIND_WRITE) begin
                        dirty_next[idx_a] = 1'b1;
                    end
                    res_next.hit = 1'b1;
                end else begin
                    idx_next = idx_inc;
                end
            end
            scbc_pkg::S_VSCAN: begin
                if (vscan_found) begin
                    victim_next = at_end ? '0 : idx_reg;
                    idx_next    = at_end ? '0 : idx_reg;
                    wptr_next   = at_end ? '0 : idx_reg;
                    ram_raddr   = at_end ? '0 : idx_a;
                end else begin
                    ref_next[idx_a] = 1'b0;
                    idx_next        = idx_inc;
                end
            end
            scbc_pkg::S_PACK: begin
                if (at_end) begin
                    count_next = wptr_reg;
                end else if (pack_drop) begin
                    if (req_reg.kind != scbc_pkg::KIND_CLOSE) begin
                        res_next.evicted    = 1'b1;
                        res_next.writeback  = dirty_cur;
                        res_next.out_file   = tag_rd.tag_file;
                        res_next.out_offset = tag_rd.tag_offset;
                    end
                    idx_next = idx_inc;
                end else begin
                    ram_we             = 1'b1;
                    ref_next[wptr_a]   = ref_cur;
                    dirty_next[wptr_a] = dirty_cur;
                    wptr_next          = wptr_reg + 1'b1;
                    idx_next           = idx_inc;
                end
            end
            scbc_pkg::S_APPEND: begin
                ram_we            = 1'b1;
                ram_waddr         = cnt_a;
                ram_wdata         = app_tag;
                ref_next[cnt_a]   = 1'b0;
                dirty_next[cnt_a] = (req_reg.kind == scbc_pkg::KIND_WRITE);
                count_next        = count_reg + 1'b1;
            end
            scbc_pkg::S_FLUSH: begin
                if (!at_end) begin
                    if (file_match && dirty_cur) begin
                        if (out_free) begin
                            out_load            = 1'b1;
                            out_data.writeback  = 1'b1;
                            out_data.out_file   = tag_rd.tag_file;
                            out_data.out_offset = tag_rd.tag_offset;
                            dirty_next[idx_a]   = 1'b0;
                            idx_next            = idx_inc;
                        end else begin
                            ram_raddr = idx_a;
                        end
                    end else begin
                        idx_next = idx_inc;
                    end
                end
            end
            scbc_pkg::S_EMIT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_data      = res_reg;
                    out_data.last = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= scbc_pkg::S_IDLE;
            count_reg   <= '0;
            ref_reg     <= '0;
            dirty_reg   <= '0;
            m_valid_reg <= 1'b0;
            cap_reg     <= CAP_W'(DEPTH);
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ref_reg   <= ref_next;
            dirty_reg <= dirty_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (psel && penable && pwrite && (paddr == scbc_pkg::REG_CAPACITY)) begin
                cap_reg <= CAP_W'(pwdata[scbc_pkg::CFG_CAP_BITS-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        wptr_reg   <= wptr_next;
        victim_reg <= victim_next;
        req_reg    <= req_next;
        res_reg    <= res_next;
        if (out_load) begin
            m_data_reg <= out_data;
        end
    end

    assign s_ready = (state_reg == scbc_pkg::S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign pready  = 1'b1;
    assign prdata  = (paddr == scbc_pkg::REG_CAPACITY) ? 32'(cap_reg) : 32'd0;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_pack_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == scbc_pkg::S_PACK) |-> (wptr_reg <= idx_reg))
        else $error("compaction write pointer ahead of read pointer");

    a_append_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == scbc_pkg::S_APPEND) |-> (count_reg < CNT_W'(DEPTH)))
        else $error("append into a full store");

    a_mid_item_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && !out_data.last) |-> (state_reg == scbc_pkg::S_FLUSH))
        else $error("non-final item outside flush");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_data.last) |=> (state_reg == scbc_pkg::S_IDLE))
        else $error("final item not followed by idle");

endmodule

`default_nettype wire

// File: bench/scbc_tag_checker.sv
// Result checker for the second-chance tag engine: predicts from accepted items and compares.
`timescale 1ns / 1ps

module scbc_tag_checker #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  scbc_pkg::in_item_t            s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  scbc_pkg::out_item_t           m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [scbc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output int unsigned                   mismatches,
    output int unsigned                   pending
);

    logic [scbc_pkg::FILE_BITS-1:0]    line_file   [DEPTH];
    logic [scbc_pkg::OFFSET_BITS-1:0]  line_offset [DEPTH];
    bit                                line_ref    [DEPTH];
    bit                                line_dirty  [DEPTH];
    int unsigned                       line_count;
    logic [scbc_pkg::CFG_CAP_BITS-1:0] capacity_reg;
    scbc_pkg::out_item_t               expected_q [$];

    function automatic void enqueue_result(input scbc_pkg::out_item_t res);
        expected_q.insert(expected_q.size(), res);
    endfunction

    task automatic drop_line(input int unsigned idx);
        for (int unsigned j = idx; j + 1 < line_count; j++) begin
            line_file[j]   = line_file[j + 1];
            line_offset[j] = line_offset[j + 1];
            line_ref[j]    = line_ref[j + 1];
            line_dirty[j]  = line_dirty[j + 1];
        end
        if (line_count > 0) line_count--;
    endtask

    task automatic predict_request(input scbc_pkg::in_item_t req);
        scbc_pkg::out_item_t res;
        int unsigned         i;
        int unsigned         victim;
        int unsigned         limit;
        bit                  found;
        res = '0;
        case (req.kind)
            scbc_pkg::KIND_FLUSH: begin
                for (i = 0; i < line_count; i++) begin
                    if (line_file[i] == req.file_id && line_dirty[i]) begin
                        line_dirty[i]  = 1'b0;
                        res            = '0;
                        res.writeback  = 1'b1;
                        res.out_file   = line_file[i];
                        res.out_offset = line_offset[i];
                        enqueue_result(res);
                    end
                end
                res      = '0;
                res.last = 1'b1;
                enqueue_result(res);
            end
            scbc_pkg::KIND_CLOSE: begin
                i = 0;
                while (i < line_count) begin
                    if (line_file[i] == req.file_id) drop_line(i);
                    else i++;
                end
                res.last = 1'b1;
                enqueue_result(res);
            end
            default: begin
                found = 1'b0;
                for (i = 0; i < line_count && !found; i++) begin
                    if (line_file[i] == req.file_id &&
                        line_offset[i] == req.block_offset) begin
                        line_ref[i] = 1'b1;
                        if (req.kind == scbc_pkg::KIND_WRITE) line_dirty[i] = 1'b1;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    res.hit = 1'b1;
                end else begin
                    limit = (capacity_reg == 0) ? 1 :
                            (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
                    if (line_count >= limit && line_count > 0) begin
                        // second chance: clear marks until an unmarked line turns up
                        for (i = 0; i < line_count; i++) begin
                            if (!line_ref[i]) break;
                            line_ref[i] = 1'b0;
                        end
                        victim         = (i < line_count) ? i : 0;
                        res.evicted    = 1'b1;
                        res.writeback  = line_dirty[victim];
                        res.out_file   = line_file[victim];
                        res.out_offset = line_offset[victim];
                        drop_line(victim);
                    end
                    if (line_count < DEPTH) begin
                        line_file[line_count]   = req.file_id;
                        line_offset[line_count] = req.block_offset;
                        line_ref[line_count]    = 1'b0;
                        line_dirty[line_count]  = (req.kind == scbc_pkg::KIND_WRITE);
                        line_count++;
                    end
                end
                res.last = 1'b1;
                enqueue_result(res);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        scbc_pkg::out_item_t want;
        if (!aresetn) begin
            expected_q.delete();
            line_count   = 0;
            capacity_reg = scbc_pkg::CFG_CAP_BITS'(DEPTH);
            mismatches   = 0;
            for (int k = 0; k < DEPTH; k++) begin
                line_ref[k]   = 1'b0;
                line_dirty[k] = 1'b0;
            end
        end else begin
            if (psel && penable && pwrite && pready && paddr == scbc_pkg::REG_CAPACITY)
                capacity_reg = pwdata[scbc_pkg::CFG_CAP_BITS-1:0];
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("result item with nothing expected: %p", m_data);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("hit", 64'(want.hit), 64'(m_data.hit));
                    check_field("evicted", 64'(want.evicted), 64'(m_data.evicted));
                    check_field("writeback", 64'(want.writeback), 64'(m_data.writeback));
                    check_field("out_file", 64'(want.out_file), 64'(m_data.out_file));
                    check_field("out_offset", 64'(want.out_offset), 64'(m_data.out_offset));
                    check_field("last", 64'(want.last), 64'(m_data.last));
                end
            end
            if (s_valid && s_ready) predict_request(s_data);
        end
        pending = expected_q.size();
    end

endmodule

// File: bench/second_chance_block_cache_tags_top_test.sv
// Testbench top for the second-chance tag engine: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module second_chance_block_cache_tags_top_test;

    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned IDLE_LIMIT  = 3000;
    localparam int unsigned SETTLE_TAIL = 60;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    scbc_pkg::in_item_t            s_data;
    logic                          m_valid;
    logic                          m_ready;
    scbc_pkg::out_item_t           m_data;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [scbc_pkg::ADDR_W-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    int unsigned                   mismatches;
    int unsigned                   pending;
    bit                            hold_req = 1'b0;
    int unsigned                   send_calm = 0;

    logic [scbc_pkg::FILE_BITS-1:0]   file_pool   [4];
    logic [scbc_pkg::OFFSET_BITS-1:0] offset_pool [8];

    second_chance_block_cache_tags_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    scbc_tag_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic scbc_pkg::in_item_t cache_req(input scbc_pkg::kind_t k,
                                                     input logic [scbc_pkg::FILE_BITS-1:0] f,
                                                     input logic [scbc_pkg::OFFSET_BITS-1:0] o);
        scbc_pkg::in_item_t req;
        req.kind         = k;
        req.file_id      = f;
        req.block_offset = o;
        return req;
    endfunction

    task automatic refresh_pools();
        foreach (file_pool[i]) file_pool[i] = scbc_pkg::FILE_BITS'($urandom);
        foreach (offset_pool[i]) offset_pool[i] = {16'($urandom), 32'($urandom)};
    endtask

    function automatic scbc_pkg::in_item_t random_req(input bit allow_close);
        scbc_pkg::in_item_t req;
        int unsigned        r;
        r = $urandom_range(0, allow_close ? 99 : 86);
        if (r < 40)      req.kind = scbc_pkg::KIND_READ;
        else if (r < 75) req.kind = scbc_pkg::KIND_WRITE;
        else if (r < 87) req.kind = scbc_pkg::KIND_FLUSH;
        else             req.kind = scbc_pkg::KIND_CLOSE;
        req.file_id = ($urandom_range(0, 9) == 0) ? scbc_pkg::FILE_BITS'($urandom)
                                                  : file_pool[$urandom_range(0, 3)];
        req.block_offset = ($urandom_range(0, 9) == 0) ? {16'($urandom), 32'($urandom)}
                                                       : offset_pool[$urandom_range(0, 7)];
        return req;
    endfunction

    task automatic send_item(input scbc_pkg::in_item_t req);
        int unsigned gap;
        gap = 0;
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(0, 99) < 5) send_calm = 15;
        else if ($urandom_range(0, 1) == 1) gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  = req;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random(input int unsigned count, input bit allow_close);
        repeat (count) send_item(random_req(allow_close));
    endtask

    // wait for every expected result, then let the engine finish its bookkeeping
    task automatic settle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_TAIL) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [scbc_pkg::CFG_CAP_BITS-1:0] cap);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = scbc_pkg::REG_CAPACITY;
        pwdata  = {27'($urandom), cap};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin : result_sink
        int unsigned stall;
        int unsigned calm;
        stall   = 0;
        calm    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (stall > 0) begin
                m_ready = 1'b0;
                stall--;
            end else begin
                m_ready = 1'b1;
                if (calm > 0) calm--;
                else if ($urandom_range(0, 99) < 4) calm = 40;
                else if ($urandom_range(0, 99) < 25) stall = pick_gap();
            end
        end
    end

    initial begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle = 0;
            else idle++;
        end
        $display("second_chance_block_cache_tags_top regression: fail");
        $finish;
    end

    initial begin : stimulus
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // full capacity: field extremes, hits, flush and close
        write_capacity(5'd16);
        send_item(cache_req(scbc_pkg::KIND_WRITE, 8'h00, 48'h0));
        send_item(cache_req(scbc_pkg::KIND_READ, 8'hFF, 48'hFFFF_FFFF_FFFF));
        send_item(cache_req(scbc_pkg::KIND_READ, 8'h00, 48'h0));
        send_item(cache_req(scbc_pkg::KIND_WRITE, 8'hFF, 48'hFFFF_FFFF_FFFF));
        send_item(cache_req(scbc_pkg::KIND_READ, 8'hA5, 48'hAAAA_AAAA_AAAA));
        send_item(cache_req(scbc_pkg::KIND_WRITE, 8'h5A, 48'h5555_5555_5555));
        send_item(cache_req(scbc_pkg::KIND_WRITE, 8'hA5, 48'h5555_5555_5555));
        send_item(cache_req(scbc_pkg::KIND_FLUSH, 8'hFF, 48'h1234_5678_9ABC));
        send_item(cache_req(scbc_pkg::KIND_FLUSH, 8'h00, 48'h0));
        send_item(cache_req(scbc_pkg::KIND_FLUSH, 8'h00, 48'hFFFF_FFFF_FFFF));
        send_item(cache_req(scbc_pkg::KIND_FLUSH, 8'h5A, 48'h0));
        send_item(cache_req(scbc_pkg::KIND_CLOSE, 8'hFF, 48'h0));
        send_item(cache_req(scbc_pkg::KIND_READ, 8'hFF, 48'hFFFF_FFFF_FFFF));
        send_item(cache_req(scbc_pkg::KIND_CLOSE, 8'hA5, 48'hFFFF_FFFF_FFFF));
        settle();

        // capacity one, set below the entry count; then every line marked
        write_capacity(5'd1);
        send_item(cache_req(scbc_pkg::KIND_WRITE, 8'h01, 48'h1000));
        send_item(cache_req(scbc_pkg::KIND_READ, 8'h01, 48'h1000));
        send_item(cache_req(scbc_pkg::KIND_READ, 8'h02, 48'h2000));
        send_item(cache_req(scbc_pkg::KIND_CLOSE, 8'h00, 48'h0));
        send_item(cache_req(scbc_pkg::KIND_CLOSE, 8'h01, 48'h0));
        send_item(cache_req(scbc_pkg::KIND_CLOSE, 8'h02, 48'h0));
        send_item(cache_req(scbc_pkg::KIND_CLOSE, 8'hFF, 48'h0));
        send_item(cache_req(scbc_pkg::KIND_WRITE, 8'h03, 48'h1));
        send_item(cache_req(scbc_pkg::KIND_READ, 8'h03, 48'h1));
        send_item(cache_req(scbc_pkg::KIND_READ, 8'h04, 48'h2));
        settle();

        refresh_pools();
        write_capacity(5'd0);
        send_random(4, 1'b1);
        settle();

        // above depth; receiver holds off so the engine backs up
        write_capacity(5'd31);
        hold_req = 1'b1;
        send_random(35, 1'b0);
        settle();

        write_capacity(5'd3);
        send_random(20, 1'b1);
        settle();

        refresh_pools();
        write_capacity(5'd16);
        send_random(25, 1'b1);
        settle();

        write_capacity(5'd5);
        send_random(25, 1'b1);
        settle();

        if (mismatches == 0)
            $display("second_chance_block_cache_tags_top regression: pass");
        else
            $display("second_chance_block_cache_tags_top regression: fail");
        $finish;
    end

endmodule

// File: files.f
hdl/scbc_pkg.sv
hdl/scbc_ram.sv
hdl/second_chance_block_cache_tags_top.sv
bench/scbc_tag_checker.sv
bench/second_chance_block_cache_tags_top_test.sv
